// ----- rtl/nssg_pkg.sv -----
// nssg_pkg: shared types and constants for the noise sound-effect sample generator
// used by every module in rtl/, no dependencies

package nssg_pkg;

    // voice pool
    localparam int VOICES  = 4;
    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    // field and state widths
    localparam int TIME_W   = 16;
    localparam int LEN_W    = 4;
    localparam int LEVEL_W  = 7;
    localparam int DIV_W    = 8;
    localparam int SHIFT_W  = 4;
    localparam int PERIOD_W = 24;
    localparam int LFSR_W   = 15;

    // constants of the voice envelope and noise source
    localparam logic [TIME_W-1:0]   IDLE_TIME     = '1;
    localparam logic [SHIFT_W-1:0]  FREEZE_SHIFT  = 4'd14;
    localparam logic [DIV_W-1:0]    DIVISOR_RESET = 8'd4;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 24'd1;
    localparam logic [LFSR_W-1:0]   LFSR_RESET    = 15'd1;

    // request kinds carried on the input tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_PLAY = 1'b1;

    // configuration register indexes
    localparam logic CFG_DIVISOR = 1'b0;
    localparam logic CFG_SHIFT   = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VOICE,
        ST_NOISE,
        ST_EMIT
    } seq_state_t;

    // result of one pass of the voice update unit
    typedef struct packed {
        logic [TIME_W-1:0]  tnext;
        logic               vol_set;
        logic [LEVEL_W-1:0] vol;
    } voice_res_t;

endpackage

// ----- rtl/noise_sfx_sample_generator.sv -----
// noise_sfx_sample_generator: top level, sequencer, voice pool and output register
// depends on nssg_pkg, nssg_voice_unit, nssg_noise

// A play transaction (tuser = 1) restarts the voice at the rotating head at the edge that
// accepts it; it gives no sample and the input stays ready. A tick transaction (tuser = 0)
// gives one sample: after the accepting edge the single voice update unit visits the voices
// one per cycle, then the noise counter is clocked and the output register is loaded, in
// the noise and emit states. The input is not ready until the sample is in the output
// register and the sequencer is back in idle, so a new tick is taken only after the last one
// is done. A finished sample waits in the output register while the next transaction is
// taken, and a tick holds in the emit state only if that register is still full and the
// receiver is not ready. Configuration writes take effect at once and should be made only
// while the block is idle.

module noise_sfx_sample_generator
    import nssg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // slave stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [3:0] play_length, [7:4] zero
    input  logic [0:0]       s_axis_tuser,   // [0] req_type
    // master stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] sample_level, [7] zero
    // configuration write port
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [DIV_W-1:0] cfg_data
);

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [VOICE_W-1:0]  idx_reg;
    logic [VOICE_W-1:0]  next_voice_reg;
    logic [TIME_W-1:0]   voice_time_reg [VOICES];
    logic [LEN_W-1:0]    voice_len_reg  [VOICES];
    logic [LEVEL_W-1:0]  vol_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic                out_valid_reg;
    logic [DIV_W-1:0]    divisor_reg;
    logic [SHIFT_W-1:0]  shift_reg;

    logic                in_fire;
    logic                last_voice;
    logic                emit_ok;
    logic                noise_step;
    logic                voice_we;
    logic                emit_load;
    logic                noise_bit;
    voice_res_t          vres;

    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign last_voice = (idx_reg == VOICE_W'(VOICES - 1));
    assign emit_ok    = !out_valid_reg || m_axis_tready;

    // shared voice update unit
    nssg_voice_unit u_voice (
        .cur_time (voice_time_reg[idx_reg]),
        .cur_len  (voice_len_reg[idx_reg]),
        .res      (vres)
    );

    // noise source
    nssg_noise u_noise (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (noise_step),
        .divisor   (divisor_reg),
        .shift     (shift_reg),
        .noise_bit (noise_bit)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_axis_tuser[0] == REQ_TICK))
                begin
                    state_next = ST_VOICE;
                end
            end
            ST_VOICE:
            begin
                if (last_voice)
                begin
                    state_next = ST_NOISE;
                end
            end
            ST_NOISE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        voice_we      = 1'b0;
        noise_step    = 1'b0;
        emit_load     = 1'b0;
        case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_VOICE: voice_we      = 1'b1;
            ST_NOISE: noise_step    = 1'b1;
            ST_EMIT:  emit_load     = emit_ok;
            default:  s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // voice index walks the pool during a tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (in_fire)
        begin
            idx_reg <= '0;
        end
        else if (voice_we && !last_voice)
        begin
            idx_reg <= idx_reg + VOICE_W'(1);
        end
    end

    // voice pool: play loads the head, tick writes back the aged voice
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_voice_reg <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_time_reg[i] <= IDLE_TIME;
                voice_len_reg[i]  <= '0;
            end
        end
        else if (in_fire && (s_axis_tuser[0] == REQ_PLAY))
        begin
            voice_time_reg[next_voice_reg] <= '0;
            voice_len_reg[next_voice_reg]  <= s_axis_tdata[LEN_W-1:0];
            if (next_voice_reg == VOICE_W'(VOICES - 1))
            begin
                next_voice_reg <= '0;
            end
            else
            begin
                next_voice_reg <= next_voice_reg + VOICE_W'(1);
            end
        end
        else if (voice_we)
        begin
            voice_time_reg[idx_reg] <= vres.tnext;
        end
    end

    // running volume, the last live voice wins
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            vol_reg <= '0;
        end
        else if (voice_we && vres.vol_set)
        begin
            vol_reg <= vres.vol;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_level_reg <= noise_bit ? '0 : vol_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_level_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RESET;
            shift_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIVISOR: divisor_reg <= cfg_data;
                CFG_SHIFT:   shift_reg   <= cfg_data[SHIFT_W-1:0];
                default:     divisor_reg <= divisor_reg;
            endcase
        end
    end

endmodule

// ----- rtl/nssg_voice_unit.sv -----
// nssg_voice_unit: shared voice update unit, ages one voice and computes its envelope
// depends on nssg_pkg

module nssg_voice_unit
    import nssg_pkg::*;
(
    input  logic [TIME_W-1:0] cur_time,
    input  logic [LEN_W-1:0]  cur_len,
    output voice_res_t        res
);

    logic              live;
    logic [TIME_W-1:0] t_inc;
    logic [TIME_W:0]   limit;
    logic              expired;
    logic [23:0]       p255;
    logic [23:0]       p255_sh;
    logic [25:0]       p1024;
    logic [25:0]       p1024_sh;
    logic [7:0]        env_a;
    logic [7:0]        env_b;
    logic [15:0]       env_prod;

    // age the voice and test it against its duration
    assign live    = (cur_time != IDLE_TIME);
    assign t_inc   = cur_time + 16'd1;
    assign limit   = 17'd1 << cur_len;
    assign expired = ({1'b0, t_inc} > limit);

    // envelope factors: t*255 and t*1024 scaled down by the length
    assign p255     = {t_inc, 8'h00} - {8'h00, t_inc};
    assign p255_sh  = p255 >> cur_len;
    assign p1024    = {t_inc, 10'b0};
    assign p1024_sh = p1024 >> cur_len;
    assign env_a    = 8'hFF - p255_sh[7:0];
    assign env_b    = 8'hFF - p1024_sh[7:0];

    // the one multiplier of the block
    assign env_prod = env_a * env_b;

    // pack the result
    always_comb
    begin
        res.tnext   = cur_time;
        res.vol_set = 1'b0;
        res.vol     = env_prod[15:9];
        if (live)
        begin
            if (expired)
            begin
                res.tnext = IDLE_TIME;
            end
            else
            begin
                res.tnext   = t_inc;
                res.vol_set = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/nssg_noise.sv -----
// nssg_noise: noise period counter and 15-bit lfsr
// depends on nssg_pkg

module nssg_noise
    import nssg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [DIV_W-1:0]   divisor,
    input  logic [SHIFT_W-1:0] shift,
    output logic               noise_bit
);

    logic [PERIOD_W-1:0] period_count_reg;
    logic [PERIOD_W-1:0] period_count_next;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [LFSR_W-1:0]   lfsr_next;
    logic [PERIOD_W-1:0] period_dec;
    logic [PERIOD_W-1:0] reload;
    logic                fb;

    assign period_dec = period_count_reg - 24'd1;
    assign reload     = {16'h0000, divisor} << shift;
    assign fb         = lfsr_reg[0] ^ lfsr_reg[1];

    // on each step count down; on zero reload and clock the lfsr unless shift has reached FREEZE_SHIFT
    always_comb
    begin
        period_count_next = period_count_reg;
        lfsr_next         = lfsr_reg;
        if (step)
        begin
            period_count_next = period_dec;
            if (period_dec == '0)
            begin
                period_count_next = reload;
                if (shift < FREEZE_SHIFT)
                begin
                    lfsr_next = {fb, lfsr_reg[LFSR_W-1:1]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= PERIOD_RESET;
            lfsr_reg         <= LFSR_RESET;
        end
        else
        begin
            period_count_reg <= period_count_next;
            lfsr_reg         <= lfsr_next;
        end
    end

    assign noise_bit = lfsr_reg[0];

endmodule

// ----- rtl/nssg_checker.sv -----
// nssg_checker: port-level assertions for noise_sfx_sample_generator, bound to the top level
// depends on nssg_pkg

module nssg_checker
    import nssg_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [0:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled sample stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("sample dropped while stalled");

    // the sample never exceeds its seven-bit range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7] == 1'b0))
        else $error("sample level out of range");

    // a tick transaction keeps the input busy while voices are processed
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_TICK)
        |=> !s_axis_tready)
        else $error("input ready during a tick");

    // a play transaction leaves the input ready at the next cycle
    a_play_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_PLAY)
        |=> s_axis_tready)
        else $error("play transaction stalled the input");

endmodule

bind noise_sfx_sample_generator nssg_checker u_nssg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for noise_sfx_sample_generator
// depends on nssg_pkg and the rtl/ sources, nothing else

module tb_top;
    import nssg_pkg::*;

    localparam int SETTLE_CYCLES = 16;      // covers a play or tick still in flight
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int SWEEP_ITEMS   = 180;
    localparam int SWEEP_PHASES  = 8;

    // register settings visited by the sweep, large periods last
    int sweep_divisor [SWEEP_PHASES] = '{1, 255, 3, 2, 1, 0, 1, 255};
    int sweep_shift   [SWEEP_PHASES] = '{0, 0, 2, 3, 0, 14, 15, 13};

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;     // [3:0] play_length, [7:4] zero
    logic [0:0]         s_axis_tuser  = '0;     // [0] req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;           // [6:0] sample_level, [7] zero
    logic               cfg_we        = 1'b0;
    logic               cfg_index     = CFG_DIVISOR;
    logic [DIV_W-1:0]   cfg_data      = '0;

    // predicted block state
    logic [TIME_W-1:0]   voice_age [VOICES];
    logic [LEN_W-1:0]    voice_exp [VOICES];
    int                  play_head;
    logic [PERIOD_W-1:0] period_left;
    logic [LFSR_W-1:0]   noise_reg;
    logic [DIV_W-1:0]    cur_divisor;
    logic [SHIFT_W-1:0]  cur_shift;

    logic [LEVEL_W-1:0]  expected_levels [$];

    int errors        = 0;
    int plays_sent    = 0;
    int ticks_sent    = 0;
    int samples_seen  = 0;
    int settings_done = 0;
    int burst_left    = 0;
    int hold_ticket   = 0;

    // receiver-side state
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          pattern_age   = 0;
    logic [15:0] stall_pattern = '1;

    always #5 clk = ~clk;

    noise_sfx_sample_generator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // age the voices, clock the noise source and return the sample of one tick
    task automatic predict_tick(output logic [LEVEL_W-1:0] level);
        logic [31:0] age;
        logic [31:0] fall;
        logic [31:0] ripple;
        logic [31:0] volume;
        volume = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (voice_age[v] != IDLE_TIME)
            begin
                age = 32'(voice_age[v]) + 32'd1;
                if ((32'd1 << voice_exp[v]) < age)
                    voice_age[v] = IDLE_TIME;
                else
                begin
                    voice_age[v] = age[TIME_W-1:0];
                    fall   = 32'd255 - (((age * 32'd255) >> voice_exp[v]) & 32'd255);
                    ripple = 32'd255 - (((age * 32'd1024) >> voice_exp[v]) & 32'd255);
                    volume = (fall * ripple) >> 9;
                end
            end
        end
        period_left = period_left - 1'b1;
        if (period_left == '0)
        begin
            period_left = PERIOD_W'(cur_divisor) << cur_shift;
            if (cur_shift < FREEZE_SHIFT)
                noise_reg = {noise_reg[0] ^ noise_reg[1], noise_reg[LFSR_W-1:1]};
        end
        level = noise_reg[0] ? '0 : volume[LEVEL_W-1:0];
    endtask

    // offer one transaction in bursts with random gaps, then predict it on acceptance
    task automatic send_req(input logic kind, input logic [LEN_W-1:0] len);
        int                 gap;
        logic [LEVEL_W-1:0] level;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, len};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind == REQ_PLAY)
        begin
            voice_age[play_head] = '0;
            voice_exp[play_head] = len;
            play_head = (play_head + 1) % VOICES;
            plays_sent++;
        end
        else
        begin
            predict_tick(level);
            expected_levels.push_back(level);
            ticks_sent++;
        end
    endtask

    // a play now and then, mostly short sounds, ticks in between
    task automatic send_random_item();
        logic [LEN_W-1:0] len;
        if ($urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 6) == 0)
                len = LEN_W'($urandom_range(8, 15));
            else
                len = LEN_W'($urandom_range(0, 6));
            send_req(REQ_PLAY, len);
        end
        else
            send_req(REQ_TICK, LEN_W'($urandom));
    endtask

    // stop offering and wait until every sample is back and the block is quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIV_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_DIVISOR)
            cur_divisor = value;
        else
            cur_shift = value[SHIFT_W-1:0];
    endtask

    // ticks straight out of reset: lfsr starts at one, no voice is live
    task automatic test_reset_state();
        repeat (4) send_req(REQ_TICK, '0);
    endtask

    // shortest and longest sounds, head wrap, restart of a live voice
    task automatic test_directed();
        send_req(REQ_PLAY, 4'd0);
        repeat (2) send_req(REQ_TICK, '0);
        send_req(REQ_PLAY, 4'd15);
        send_req(REQ_PLAY, 4'd1);
        send_req(REQ_PLAY, 4'd3);
        send_req(REQ_PLAY, 4'd2);          // head wraps back to the first voice
        send_req(REQ_PLAY, 4'd0);          // restarts the long voice while it is live
        repeat (4) send_req(REQ_TICK, '0);
        send_req(REQ_TICK, 4'd15);         // length field ignored on a tick
        send_req(REQ_PLAY, 4'd15);
        repeat (3) send_req(REQ_TICK, 4'd10);
    endtask

    // receiver holds off while ticks keep coming, so the input has to stall
    task automatic test_backpressure();
        hold_ticket++;
        burst_left = 60;
        send_req(REQ_PLAY, 4'd12);
        repeat (59) send_req(REQ_TICK, LEN_W'($urandom));
        wait_idle();
    endtask

    // sender pauses mid-stream until the pipeline is empty
    task automatic test_drain_pause();
        repeat (20) send_random_item();
        wait_idle();
        repeat (20) send_random_item();
        wait_idle();
    endtask

    task automatic test_random_mix();
        repeat (280) send_random_item();
        wait_idle();
    endtask

    // walk divisor and shift through their extremes, random traffic in each setting
    task automatic test_register_sweep();
        for (int p = 0; p < SWEEP_PHASES; p++)
        begin
            wait_idle();
            write_reg(CFG_DIVISOR, DIV_W'(sweep_divisor[p]));
            write_reg(CFG_SHIFT, DIV_W'(sweep_shift[p]));
            settings_done++;
            repeat (SWEEP_ITEMS) send_random_item();
        end
    endtask

    // receiver ready: long hold on request, otherwise a rotating stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_served != hold_ticket)
        begin
            hold_served = hold_ticket;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom | $urandom);
                    default: stall_pattern = 16'($urandom & $urandom);
                endcase
                pattern_age = 64;
            end
            pattern_age--;
            m_axis_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // compare each output transaction with the oldest predicted sample
    always @(posedge clk)
    begin : check_samples
        logic [LEVEL_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_levels.size() == 0)
                report_mismatch("sample with nothing expected", int'(m_axis_tdata), 0);
            else
            begin
                want = expected_levels.pop_front();
                samples_seen++;
                if (m_axis_tdata[LEVEL_W-1:0] !== want)
                    report_mismatch("sample_level", int'(m_axis_tdata[LEVEL_W-1:0]), int'(want));
                if (m_axis_tdata[7:LEVEL_W] !== '0)
                    report_mismatch("tdata padding", int'(m_axis_tdata[7:LEVEL_W]), 0);
            end
        end
    end

    // run limit
    initial
    begin
        #5000000;
        $display("timeout: %0d samples still outstanding", expected_levels.size());
        $display("noise_sfx_sample_generator: mismatch");
        $finish;
    end

    initial
    begin
        // predicted state after reset
        for (int v = 0; v < VOICES; v++)
        begin
            voice_age[v] = IDLE_TIME;
            voice_exp[v] = '0;
        end
        play_head   = 0;
        period_left = PERIOD_RESET;
        noise_reg   = LFSR_RESET;
        cur_divisor = DIVISOR_RESET;
        cur_shift   = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random_mix();
        test_register_sweep();
        wait_idle();

        $display("covered %0d plays and %0d ticks, %0d samples checked",
                 plays_sent, ticks_sent, samples_seen);
        $display("%0d divisor/shift settings after reset, long output hold-off included",
                 settings_done);
        if (errors == 0)
            $display("noise_sfx_sample_generator: match");
        else
            $display("noise_sfx_sample_generator: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/nssg_pkg.sv
rtl/nssg_voice_unit.sv
rtl/nssg_noise.sv
rtl/noise_sfx_sample_generator.sv
rtl/nssg_checker.sv
verif/tb_top.sv
